>>> hw/rtl/button_press_mode_controller_macros.svh
// Assertion helpers shared by bpmc_core and the top-level controller.
`ifndef BUTTON_PRESS_MODE_CONTROLLER_MACROS_SVH
`define BUTTON_PRESS_MODE_CONTROLLER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BPMC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define BPMC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/bpmc_pkg.sv
package bpmc_pkg;

	// Timer and register widths
	localparam int TIMER_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

	typedef logic [TIMER_WIDTH-1:0] timer_t;
	typedef logic [CFG_WIDTH-1:0]   cfg_val_t;
	typedef logic [CMP_WIDTH-1:0]   cmp_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

	localparam timer_t TIMER_MAX = {TIMER_WIDTH{1'b1}};

	// Register indexes and reset values
	localparam cfg_idx_t CFG_NOISE  = 2'd0;
	localparam cfg_idx_t CFG_SHORT  = 2'd1;
	localparam cfg_idx_t CFG_LONG   = 2'd2;
	localparam cfg_idx_t CFG_WINDOW = 2'd3;

	localparam cfg_val_t NOISE_RST  = 16'd25;
	localparam cfg_val_t SHORT_RST  = 16'd500;
	localparam cfg_val_t LONG_RST   = 16'd2000;
	localparam cfg_val_t WINDOW_RST = 16'd800;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_FIRST_SHORT = 3'd1,
		EV_RADIO       = 3'd2,
		EV_MEASURE     = 3'd3,
		EV_POWER_OFF   = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		LED_OFF   = 2'd0,
		LED_BLUE  = 2'd1,
		LED_GREEN = 2'd2,
		LED_RED   = 2'd3
	} led_t;

	typedef enum logic [1:0] {
		RADIO_BLE      = 2'd0,
		RADIO_DIRECT64 = 2'd1,
		RADIO_DIRECT32 = 2'd2
	} radio_t;

	typedef enum logic {
		MEAS_ECG = 1'b0,
		MEAS_EMG = 1'b1
	} meas_t;

	typedef struct packed {
		cfg_val_t noise_limit;
		cfg_val_t short_limit;
		cfg_val_t long_limit;
		cfg_val_t double_window;
	} cfg_t;

	typedef struct packed {
		led_t   led_color;
		logic   led_override;
		event_t event_code;
		radio_t radio_sel;
		meas_t  measure_mode;
	} result_t;

	// Saturating increment of a timer
	function automatic timer_t sat_inc(input timer_t v);
		return (v == TIMER_MAX) ? TIMER_MAX : v + timer_t'(1);
	endfunction

	function automatic cmp_t tmr_to_cmp(input timer_t v);
		return cmp_t'(v);
	endfunction

	function automatic cmp_t cfg_to_cmp(input cfg_val_t v);
		return cmp_t'(v);
	endfunction

endpackage

>>> hw/rtl/bpmc_cfg.sv
module bpmc_cfg
	import bpmc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr_en,
	input  cfg_idx_t cfg_index,
	input  cfg_val_t cfg_data,
	output cfg_t     cfg
);

	cfg_t cfg_q;

	// Write the addressed limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_limit   <= NOISE_RST;
			cfg_q.short_limit   <= SHORT_RST;
			cfg_q.long_limit    <= LONG_RST;
			cfg_q.double_window <= WINDOW_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_NOISE:  cfg_q.noise_limit   <= cfg_data;
				CFG_SHORT:  cfg_q.short_limit   <= cfg_data;
				CFG_LONG:   cfg_q.long_limit    <= cfg_data;
				CFG_WINDOW: cfg_q.double_window <= cfg_data;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/bpmc_core.sv
module bpmc_core
	import bpmc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  logic    level,
	input  cfg_t    cfg,
	output result_t res
);

	`include "button_press_mode_controller_macros.svh"

	logic   was_q;
	timer_t hold_q;
	timer_t since_q;
	logic   armed_q;
	radio_t radio_q;
	meas_t  measure_q;
	led_t   color_q;

	logic   was_n;
	timer_t hold_n;
	timer_t since_n;
	logic   armed_n;
	radio_t radio_n;
	meas_t  measure_n;
	led_t   color_n;
	event_t event_n;
	timer_t len;
	cmp_t   hold_c;
	cmp_t   len_c;
	cmp_t   noise_c;
	cmp_t   short_c;
	cmp_t   long_c;
	cmp_t   window_c;

	assign noise_c  = cfg_to_cmp(cfg.noise_limit);
	assign short_c  = cfg_to_cmp(cfg.short_limit);
	assign long_c   = cfg_to_cmp(cfg.long_limit);
	assign window_c = cfg_to_cmp(cfg.double_window);
	assign len      = sat_inc(hold_q);
	assign len_c    = tmr_to_cmp(len);
	assign hold_n   = level ? (was_q ? sat_inc(hold_q) : '0) : hold_q;
	assign hold_c   = tmr_to_cmp(hold_n);

	// Next state for one tick
	always_comb begin
		was_n     = was_q;
		since_n   = sat_inc(since_q);
		armed_n   = armed_q;
		radio_n   = radio_q;
		measure_n = measure_q;
		color_n   = color_q;
		event_n   = EV_NONE;
		if (level) begin
			was_n = 1'b1;
			if (hold_c > noise_c && hold_c < short_c)
				color_n = LED_BLUE;
			if (hold_c > short_c && hold_c < long_c)
				color_n = LED_GREEN;
			if (hold_c > long_c)
				color_n = LED_RED;
		end else if (was_q) begin
			was_n = 1'b0;
			if (len_c > noise_c) begin
				if (len_c < short_c) begin
					if (!armed_q || tmr_to_cmp(since_n) > window_c) begin
						armed_n = 1'b1;
						since_n = '0;
						event_n = EV_FIRST_SHORT;
					end else begin
						armed_n = 1'b0;
						case (radio_q)
							RADIO_BLE:      radio_n = RADIO_DIRECT64;
							RADIO_DIRECT64: radio_n = RADIO_DIRECT32;
							default:        radio_n = RADIO_BLE;
						endcase
						event_n = EV_RADIO;
					end
				end else if (len_c < long_c) begin
					measure_n = meas_t'(~measure_q);
					event_n   = EV_MEASURE;
				end else begin
					event_n = EV_POWER_OFF;
				end
			end
		end
	end

	// Advance state on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_q     <= 1'b0;
			hold_q    <= '0;
			since_q   <= '0;
			armed_q   <= 1'b0;
			radio_q   <= RADIO_BLE;
			measure_q <= MEAS_ECG;
			color_q   <= LED_OFF;
		end else if (fire) begin
			was_q     <= was_n;
			hold_q    <= hold_n;
			since_q   <= since_n;
			armed_q   <= armed_n;
			radio_q   <= radio_n;
			measure_q <= measure_n;
			color_q   <= color_n;
		end
	end

	assign res.led_color    = color_n;
	assign res.led_override = level;
	assign res.event_code   = event_n;
	assign res.radio_sel    = radio_n;
	assign res.measure_mode = measure_n;

	`BPMC_ASSERT(a_radio_hold, fire && event_n != EV_RADIO |=> $stable(radio_q), "radio moved")
	`BPMC_ASSERT(a_meas_hold, fire && event_n != EV_MEASURE |=> $stable(measure_q), "measure moved")
	`BPMC_ASSERT(a_idle_hold, !fire |=> $stable({was_q, hold_q, since_q}), "state moved idle")
	`BPMC_ASSERT(a_radio_legal, radio_q <= RADIO_DIRECT32, "radio mode reached unused code")

endmodule

>>> hw/rtl/button_press_mode_controller.sv
// Button press mode controller. Each transfer on the input channel is one
// millisecond tick with the sampled button level; each tick yields exactly one
// result transfer with the indicator colour, override flag, press event and the
// current radio and measurement modes. The block takes one tick per clock
// cycle unless out_stall holds a waiting result: a tick sits in the input
// register after its transfer, is evaluated against the limit registers in a
// single pass, and its result loads the output register when the tick
// advances. The output register lets a new tick enter while a result waits;
// when both are full, in_stall follows out_stall. Limit registers take effect
// on the next tick after a write.
module button_press_mode_controller
	import bpmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        button_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  led_color,
	output logic        led_override,
	output logic [2:0]  event_code,
	output logic [1:0]  radio_mode_out,
	output logic        measure_mode_out
);

	`include "button_press_mode_controller_macros.svh"

	cfg_t    cfg;
	result_t res;
	logic    valid_s1;
	logic    level_s1;
	logic    adv_s1;
	logic    in_fire;
	logic    out_valid_q;
	result_t res_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_fire  = in_valid && !in_stall;

	bpmc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_idx_t'(cfg_index)),
		.cfg_data  (cfg_val_t'(cfg_data)),
		.cfg       (cfg)
	);

	bpmc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s1),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Hold the accepted tick until it is evaluated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			level_s1 <= button_level;
		end
	end

	// Drop the result once transferred, load a new one on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign led_color        = res_q.led_color;
	assign led_override     = res_q.led_override;
	assign event_code       = res_q.event_code;
	assign radio_mode_out   = res_q.radio_sel;
	assign measure_mode_out = res_q.measure_mode;

	`BPMC_ASSERT(a_held_quiet,
		out_valid_q && res_q.led_override |-> res_q.event_code == EV_NONE, "event while held")
	`BPMC_ASSERT(a_result_follows_tick, adv_s1 |=> out_valid_q, "evaluated tick produced no result")
	`BPMC_ASSERT(a_stall_keeps_result,
		out_valid_q && out_stall |=> out_valid_q && $stable(res_q), "stalled result lost")

endmodule
